### rtl/bfsp_pkg.sv
// ----------------------------------------------------------------------------
// bfsp_pkg: shared types and constants of the shortest-path unit
// Field widths, register codes, saturation bounds and the command/status
// structs passed between controller and datapath.
// ----------------------------------------------------------------------------
package bfsp_pkg;

    localparam int NODE_W     = 5;
    localparam int DIST_W     = 24;
    localparam int SRC_W      = 5;
    localparam int NCOUNT_W   = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_NODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT  = 1'd1;

    localparam logic [NCOUNT_W-1:0] NODE_COUNT_RESET = 6'd5;

    localparam logic signed [DIST_W-1:0] DIST_MAX = 24'sh7FFFFF;
    localparam logic signed [DIST_W-1:0] DIST_MIN = -24'sh800000;

    typedef struct packed {
        logic edge_wr;    // store the accepted edge word
        logic init;       // start a run: clear reach flags, seed the source
        logic edge_rd;    // read one stored edge
        logic dist_rd;    // read distances of tail and head
        logic relax;      // apply the relaxation of the current edge
        logic emit_rd;    // read the distance of the node being reported
        logic emit_ld;    // load the result register
        logic emit_last;  // the node being loaded is the final one
    } bfsp_cmd_t;

    typedef struct packed {
        logic out_free;   // result register empty or emptying this cycle
        logic single;     // one node in use: no relaxation passes
    } bfsp_status_t;

endpackage

### rtl/bfsp_if.sv
// ----------------------------------------------------------------------------
// bfsp_if: channel interfaces of the shortest-path unit
// Edge input, result output and configuration write channels, each with
// valid/ready and source/sink modports.
// ----------------------------------------------------------------------------
interface bfsp_edge_if #(
    parameter int COST_BITS = 16
) ();
    import bfsp_pkg::*;

    logic                        valid;
    logic                        ready;
    logic [NODE_W-1:0]           from_node;
    logic [NODE_W-1:0]           to_node;
    logic signed [COST_BITS-1:0] edge_cost;
    logic                        last_edge;

    modport source (output valid, from_node, to_node, edge_cost, last_edge, input ready);
    modport sink   (input valid, from_node, to_node, edge_cost, last_edge, output ready);
endinterface

interface bfsp_result_if ();
    import bfsp_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [NODE_W-1:0]        node_index;
    logic signed [DIST_W-1:0] distance;
    logic                     reachable;
    logic                     last_node;

    modport source (output valid, node_index, distance, reachable, last_node, input ready);
    modport sink   (input valid, node_index, distance, reachable, last_node, output ready);
endinterface

interface bfsp_cfg_if ();
    import bfsp_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/bfsp_ram.sv
// ----------------------------------------------------------------------------
// bfsp_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents undefined at reset.
// ----------------------------------------------------------------------------
module bfsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

### rtl/bfsp_ctrl.sv
// ----------------------------------------------------------------------------
// bfsp_ctrl: sequencer of the shortest-path unit
// Counts loaded edges, walks edges and passes during relaxation, then walks
// the nodes to report them.
// ----------------------------------------------------------------------------
module bfsp_ctrl #(
    parameter int MAX_NODES = 32,
    parameter int MAX_EDGES = 256,
    parameter int CNT_W     = $clog2(MAX_NODES + 1),
    parameter int NODE_AW   = $clog2(MAX_NODES),
    parameter int ECNT_W    = $clog2(MAX_EDGES + 1),
    parameter int EDGE_AW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_last,
    output logic                   in_ready,
    input  logic [CNT_W-1:0]       n_eff,
    input  bfsp_pkg::bfsp_status_t status,
    output bfsp_pkg::bfsp_cmd_t    cmd,
    output logic [EDGE_AW-1:0]     edge_waddr,
    output logic [EDGE_AW-1:0]     edge_raddr,
    output logic [NODE_AW-1:0]     node_addr
);
    import bfsp_pkg::*;

    typedef enum logic [5:0] {
        ST_LOAD        = 6'b000001,
        ST_RELAX_ADDR  = 6'b000010,
        ST_RELAX_FETCH = 6'b000100,
        ST_RELAX_UPD   = 6'b001000,
        ST_EMIT_RD     = 6'b010000,
        ST_EMIT_LD     = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    logic [ECNT_W-1:0]  cnt_reg, cnt_next;
    logic [EDGE_AW-1:0] e_reg, e_next;
    logic [CNT_W-1:0]   pass_reg, pass_next;
    logic [NODE_AW-1:0] k_reg, k_next;
    logic               accept;
    logic               room;
    logic               last_e;
    logic               last_pass;
    logic               last_k;

    assign in_ready   = (state_reg == ST_LOAD);
    assign accept     = in_valid & in_ready;
    assign room       = (cnt_reg < ECNT_W'(MAX_EDGES));
    assign edge_waddr = EDGE_AW'(cnt_reg);
    assign edge_raddr = e_reg;
    assign node_addr  = k_reg;
    assign last_e     = (e_reg == EDGE_AW'(ECNT_W'(cnt_reg - ECNT_W'(1))));
    assign last_pass  = (CNT_W'(pass_reg + CNT_W'(1)) == CNT_W'(n_eff - CNT_W'(1)));
    assign last_k     = (CNT_W'(k_reg) == CNT_W'(n_eff - CNT_W'(1)));

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        e_next     = e_reg;
        pass_next  = pass_reg;
        k_next     = k_reg;
        cmd        = '0;
        case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    cmd.edge_wr = room;
                    cnt_next    = cnt_reg + ECNT_W'(room);
                    if (in_last)
                    begin
                        cmd.init  = 1'b1;
                        e_next    = '0;
                        pass_next = '0;
                        k_next    = '0;
                        if (status.single)
                        begin
                            cnt_next   = '0;
                            state_next = ST_EMIT_RD;
                        end
                        else
                        begin
                            state_next = ST_RELAX_ADDR;
                        end
                    end
                end
            end
            ST_RELAX_ADDR:
            begin
                cmd.edge_rd = 1'b1;
                state_next  = ST_RELAX_FETCH;
            end
            ST_RELAX_FETCH:
            begin
                cmd.dist_rd = 1'b1;
                state_next  = ST_RELAX_UPD;
            end
            ST_RELAX_UPD:
            begin
                cmd.relax  = 1'b1;
                state_next = ST_RELAX_ADDR;
                if (last_e)
                begin
                    e_next = '0;
                    if (last_pass)
                    begin
                        cnt_next   = '0;
                        state_next = ST_EMIT_RD;
                    end
                    else
                    begin
                        pass_next = pass_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    e_next = e_reg + EDGE_AW'(1);
                end
            end
            ST_EMIT_RD:
            begin
                if (status.out_free)
                begin
                    cmd.emit_rd = 1'b1;
                    state_next  = ST_EMIT_LD;
                end
            end
            ST_EMIT_LD:
            begin
                cmd.emit_ld   = 1'b1;
                cmd.emit_last = last_k;
                if (last_k)
                begin
                    state_next = ST_LOAD;
                end
                else
                begin
                    k_next     = k_reg + NODE_AW'(1);
                    state_next = ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            e_reg     <= '0;
            pass_reg  <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            e_reg     <= e_next;
            pass_reg  <= pass_next;
            k_reg     <= k_next;
        end
    end
endmodule

### rtl/bfsp_dpath.sv
// ----------------------------------------------------------------------------
// bfsp_dpath: datapath of the shortest-path unit
// Configuration registers, edge store, distance store, reach flags, the
// saturating relaxation adder and the result register.
// ----------------------------------------------------------------------------
module bfsp_dpath #(
    parameter int MAX_NODES = 32,
    parameter int MAX_EDGES = 256,
    parameter int COST_BITS = 16,
    parameter int CNT_W     = $clog2(MAX_NODES + 1),
    parameter int NODE_AW   = $clog2(MAX_NODES),
    parameter int EDGE_AW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration
    input  logic                            cfg_we,
    input  logic [bfsp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bfsp_pkg::CFG_DATA_W-1:0] cfg_data,
    // edge payload
    input  logic [bfsp_pkg::NODE_W-1:0]     from_node,
    input  logic [bfsp_pkg::NODE_W-1:0]     to_node,
    input  logic signed [COST_BITS-1:0]     edge_cost,
    // controller
    input  bfsp_pkg::bfsp_cmd_t             cmd,
    output bfsp_pkg::bfsp_status_t          status,
    output logic [CNT_W-1:0]                n_eff,
    input  logic [EDGE_AW-1:0]              edge_waddr,
    input  logic [EDGE_AW-1:0]              edge_raddr,
    input  logic [NODE_AW-1:0]              node_addr,
    // result register
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [bfsp_pkg::NODE_W-1:0]     out_node_index,
    output logic signed [bfsp_pkg::DIST_W-1:0] out_distance,
    output logic                            out_reachable,
    output logic                            out_last_node
);
    import bfsp_pkg::*;

    localparam int EDGE_W = 2 * NODE_W + COST_BITS;
    localparam int SUM_W  = ((COST_BITS > DIST_W) ? COST_BITS : DIST_W) + 1;
    localparam int CMP_W  = 8;

    logic [SRC_W-1:0]     source_reg;
    logic [NCOUNT_W-1:0]  count_reg;
    logic [MAX_NODES-1:0] reached_reg, reached_next;

    logic                     out_valid_reg;
    logic [NODE_W-1:0]        out_index_reg;
    logic signed [DIST_W-1:0] out_dist_reg;
    logic                     out_reach_reg;
    logic                     out_last_reg;

    logic [EDGE_W-1:0]           edge_rdata;
    logic [NODE_W-1:0]           tail;
    logic [NODE_W-1:0]           head;
    logic signed [COST_BITS-1:0] cost;
    logic [NODE_AW-1:0]          tail_addr;
    logic [NODE_AW-1:0]          head_addr;
    logic [NODE_AW-1:0]          src_addr;
    logic                        src_ok;

    logic [DIST_W-1:0]        dist_a_rdata;
    logic [DIST_W-1:0]        dist_b_rdata;
    logic signed [DIST_W-1:0] dist_u;
    logic signed [DIST_W-1:0] dist_v;
    logic signed [SUM_W-1:0]  sum;
    logic signed [DIST_W-1:0] cand;
    logic                     edge_ok;
    logic                     update;

    logic                     dist_we;
    logic [NODE_AW-1:0]       dist_waddr;
    logic [DIST_W-1:0]        dist_wdata;
    logic [NODE_AW-1:0]       dist_a_raddr;

    // Clamp the node count into 1..MAX_NODES.
    always_comb
    begin
        if (count_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (CMP_W'(count_reg) > CMP_W'(MAX_NODES))
        begin
            n_eff = CNT_W'(MAX_NODES);
        end
        else
        begin
            n_eff = CNT_W'(count_reg);
        end
    end

    assign status.out_free = ~out_valid_reg | out_ready;
    assign status.single   = (n_eff == CNT_W'(1));

    bfsp_ram #(
        .WIDTH (EDGE_W),
        .DEPTH (MAX_EDGES),
        .AW    (EDGE_AW)
    ) u_edge_ram (
        .clk     (clk),
        .wr_en   (cmd.edge_wr),
        .wr_addr (edge_waddr),
        .wr_data ({from_node, to_node, edge_cost}),
        .rd_en   (cmd.edge_rd),
        .rd_addr (edge_raddr),
        .rd_data (edge_rdata)
    );

    assign tail      = edge_rdata[EDGE_W-1 -: NODE_W];
    assign head      = edge_rdata[COST_BITS +: NODE_W];
    assign cost      = edge_rdata[COST_BITS-1:0];
    assign tail_addr = NODE_AW'(tail);
    assign head_addr = NODE_AW'(head);
    assign src_addr  = NODE_AW'(source_reg);
    assign src_ok    = (CMP_W'(source_reg) < CMP_W'(n_eff));

    // Two copies of the distance store give tail and head reads in the same cycle.
    assign dist_we      = cmd.init | update;
    assign dist_waddr   = cmd.init ? src_addr : head_addr;
    assign dist_wdata   = cmd.init ? '0 : cand;
    assign dist_a_raddr = cmd.emit_rd ? node_addr : tail_addr;

    bfsp_ram #(
        .WIDTH (DIST_W),
        .DEPTH (MAX_NODES),
        .AW    (NODE_AW)
    ) u_dist_ram_a (
        .clk     (clk),
        .wr_en   (dist_we),
        .wr_addr (dist_waddr),
        .wr_data (dist_wdata),
        .rd_en   (cmd.dist_rd | cmd.emit_rd),
        .rd_addr (dist_a_raddr),
        .rd_data (dist_a_rdata)
    );

    bfsp_ram #(
        .WIDTH (DIST_W),
        .DEPTH (MAX_NODES),
        .AW    (NODE_AW)
    ) u_dist_ram_b (
        .clk     (clk),
        .wr_en   (dist_we),
        .wr_addr (dist_waddr),
        .wr_data (dist_wdata),
        .rd_en   (cmd.dist_rd),
        .rd_addr (head_addr),
        .rd_data (dist_b_rdata)
    );

    assign dist_u = dist_a_rdata;
    assign dist_v = dist_b_rdata;
    assign sum    = SUM_W'(dist_u) + SUM_W'(cost);

    always_comb
    begin
        if (sum > SUM_W'(DIST_MAX))
        begin
            cand = DIST_MAX;
        end
        else if (sum < SUM_W'(DIST_MIN))
        begin
            cand = DIST_MIN;
        end
        else
        begin
            cand = DIST_W'(sum);
        end
    end

    // Skip edges with an endpoint out of range or an unreached tail.
    assign edge_ok = (CMP_W'(tail) < CMP_W'(n_eff)) && (CMP_W'(head) < CMP_W'(n_eff))
                     && reached_reg[tail_addr];
    assign update  = cmd.relax && edge_ok && (!reached_reg[head_addr] || (cand < dist_v));

    always_comb
    begin
        reached_next = reached_reg;
        if (cmd.init)
        begin
            reached_next = '0;
            if (src_ok)
            begin
                reached_next[src_addr] = 1'b1;
            end
        end
        else if (update)
        begin
            reached_next[head_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_reg    <= '0;
            count_reg     <= NODE_COUNT_RESET;
            reached_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            reached_reg <= reached_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SOURCE_NODE: source_reg <= cfg_data[SRC_W-1:0];
                    REG_NODE_COUNT:  count_reg  <= cfg_data[NCOUNT_W-1:0];
                    default:         ;
                endcase
            end
            if (cmd.emit_ld)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_ld)
        begin
            out_index_reg <= NODE_W'(node_addr);
            out_dist_reg  <= reached_reg[node_addr] ? signed'(dist_a_rdata) : '0;
            out_reach_reg <= reached_reg[node_addr];
            out_last_reg  <= cmd.emit_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_node_index = out_index_reg;
    assign out_distance   = out_dist_reg;
    assign out_reachable  = out_reach_reg;
    assign out_last_node  = out_last_reg;
endmodule

### rtl/bellman_ford_shortest_paths_unit.sv
// ----------------------------------------------------------------------------
// bellman_ford_shortest_paths_unit: single-source shortest paths over an
// edge list
//
// Load directed weighted edges on the edges channel, one word per cycle; the
// word with last_edge set closes the list and starts the run. Edges beyond
// MAX_EDGES are dropped, but their last_edge mark still counts. The cfg
// channel writes source_node (index 0) and node_count (index 1); it is always
// ready; the user must write it only while the unit is idle; the unit does
// not enforce this. A run makes n-1 relaxation passes, n being node_count
// clamped to 1..MAX_NODES, over the stored edges in load order, each edge in
// three steps (edge read, distance read, update), then reports one word per
// node, node 0 first, as the output frees; last_node marks the final word.
// Unreached nodes report reachable=0 and distance 0; sums saturate to 24 bits.
// edges.ready is high only between runs. A stalled results word holds in the
// output register; the next edge list may already load while it waits.
// Reset clears the edge count, the reach flags and the configuration
// (source 0, node count 5); the edge and distance stores need no clearing.
// ----------------------------------------------------------------------------
module bellman_ford_shortest_paths_unit #(
    parameter int MAX_NODES = 32,
    parameter int MAX_EDGES = 256,
    parameter int COST_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    bfsp_edge_if.sink     edges,
    bfsp_result_if.source results,
    bfsp_cfg_if.sink      cfg
);
    import bfsp_pkg::*;

    localparam int CNT_W   = $clog2(MAX_NODES + 1);
    localparam int NODE_AW = $clog2(MAX_NODES);
    localparam int ECNT_W  = $clog2(MAX_EDGES + 1);
    localparam int EDGE_AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

    bfsp_cmd_t          cmd;
    bfsp_status_t       status;
    logic [CNT_W-1:0]   n_eff;
    logic [EDGE_AW-1:0] edge_waddr;
    logic [EDGE_AW-1:0] edge_raddr;
    logic [NODE_AW-1:0] node_addr;
    logic               in_ready;

    // Configuration registers take every word.
    assign cfg.ready   = 1'b1;
    assign edges.ready = in_ready;

    bfsp_ctrl #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES),
        .CNT_W     (CNT_W),
        .NODE_AW   (NODE_AW),
        .ECNT_W    (ECNT_W),
        .EDGE_AW   (EDGE_AW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (edges.valid),
        .in_last    (edges.last_edge),
        .in_ready   (in_ready),
        .n_eff      (n_eff),
        .status     (status),
        .cmd        (cmd),
        .edge_waddr (edge_waddr),
        .edge_raddr (edge_raddr),
        .node_addr  (node_addr)
    );

    bfsp_dpath #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES),
        .COST_BITS (COST_BITS),
        .CNT_W     (CNT_W),
        .NODE_AW   (NODE_AW),
        .EDGE_AW   (EDGE_AW)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg.valid & cfg.ready),
        .cfg_index      (cfg.index),
        .cfg_data       (cfg.data),
        .from_node      (edges.from_node),
        .to_node        (edges.to_node),
        .edge_cost      (edges.edge_cost),
        .cmd            (cmd),
        .status         (status),
        .n_eff          (n_eff),
        .edge_waddr     (edge_waddr),
        .edge_raddr     (edge_raddr),
        .node_addr      (node_addr),
        .out_ready      (results.ready),
        .out_valid      (results.valid),
        .out_node_index (results.node_index),
        .out_distance   (results.distance),
        .out_reachable  (results.reachable),
        .out_last_node  (results.last_node)
    );

`ifndef SYNTHESIS
    // The closing word starts a run: drop ready right after it.
    a_close_stops_input: assert property (@(posedge clk) disable iff (!rst_n)
        edges.valid && edges.ready && edges.last_edge |=> !edges.ready)
        else $error("edge input still ready after closing word");

    // A result is loaded only into an empty output register.
    a_load_into_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_ld |-> !results.valid)
        else $error("result register overwritten");

    // Loading the final node shows it with last_node and reopens the input.
    a_final_reopens: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_ld && cmd.emit_last |=> results.valid && results.last_node && edges.ready)
        else $error("final result not shown or input not reopened");
`endif
endmodule

### tb/sv/tb_bellman_ford_shortest_paths_unit.sv
// ----------------------------------------------------------------------------
// tb_bellman_ford_shortest_paths_unit: shortest-path unit testbench
// Loads edge lists through the edge channel, writes source and node count
// between runs, and checks every results word against a shortest-path
// solver kept inside the bench. The sender pauses in bursts and the receiver
// stalls on its own pattern, once for a long stretch to back up the unit.
// ----------------------------------------------------------------------------
module tb_bellman_ford_shortest_paths_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import bfsp_pkg::*;

    localparam int MAX_NODES     = 32;
    localparam int MAX_EDGES     = 256;
    localparam int COST_BITS     = 16;
    localparam int IDLE_LIMIT    = 20000;   // cycles with no handshake at all
    localparam int LONG_HOLD     = 400;     // receiver hold-off, in cycles
    localparam int SETTLE_CYCLES = 16;      // quiet time before a register write
    localparam int RANDOM_ITEMS  = 55;

    typedef struct packed {
        logic [NODE_W-1:0]           tail;
        logic [NODE_W-1:0]           head;
        logic signed [COST_BITS-1:0] cost;
        logic                        closing;
    } edge_word_t;

    typedef struct packed {
        logic [NODE_W-1:0]        node_index;
        logic signed [DIST_W-1:0] distance;
        logic                     reachable;
        logic                     last_node;
    } node_report_t;

    // receiver stall patterns
    typedef enum int {
        RX_OPEN,      // always ready
        RX_COIN,      // ready on a coin flip
        RX_CADENCE,   // low one cycle in three
        RX_SPARSE     // ready one cycle in four, on average
    } rx_mode_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    bfsp_edge_if #(.COST_BITS(COST_BITS)) edges_ch ();
    bfsp_result_if                        results_ch ();
    bfsp_cfg_if                           cfg_ch ();

    bellman_ford_shortest_paths_unit #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES),
        .COST_BITS (COST_BITS)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .edges   (edges_ch),
        .results (results_ch),
        .cfg     (cfg_ch)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------------
    // Solver state: a private copy of the edge list and of both registers.
    // ------------------------------------------------------------------------
    logic [NODE_W-1:0]           list_tail [MAX_EDGES];
    logic [NODE_W-1:0]           list_head [MAX_EDGES];
    logic signed [COST_BITS-1:0] list_cost [MAX_EDGES];
    int                          list_len = 0;
    logic [SRC_W-1:0]            model_source = '0;
    logic [NCOUNT_W-1:0]         model_count  = NODE_COUNT_RESET;

    node_report_t pending_reports[$];   // distances still owed by the unit

    int error_count = 0;
    int idle_cycles = 0;
    int items_sent  = 0;
    int burst_left  = 0;
    bit offering    = 1'b0;   // what edges_ch.valid will hold after this step
    bit hold_req    = 1'b0;   // ask the receiver for one long hold-off

    // Drive every input known before the first edge.
    initial begin
        edges_ch.valid     = 1'b0;
        edges_ch.from_node = '0;
        edges_ch.to_node   = '0;
        edges_ch.edge_cost = '0;
        edges_ch.last_edge = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = REG_SOURCE_NODE;
        cfg_ch.data        = '0;
    end

    // Node count in use: zero acts as one, anything above the store as the max.
    function automatic int nodes_in_use();
        int n;
        n = int'(model_count);
        if (n < 1)
            n = 1;
        if (n > MAX_NODES)
            n = MAX_NODES;
        return n;
    endfunction

    function automatic longint clamp_dist(longint x);
        if (x > longint'(DIST_MAX))
            return longint'(DIST_MAX);
        if (x < longint'(DIST_MIN))
            return longint'(DIST_MIN);
        return x;
    endfunction

    // Run the relaxation passes over the stored list, queue one report per
    // node, and start a new list.
    function automatic void solve_paths();
        int           n;
        int           u;
        int           v;
        longint       cand;
        longint       node_dist [MAX_NODES];
        bit           seen [MAX_NODES];
        node_report_t rep;

        n = nodes_in_use();
        for (int k = 0; k < MAX_NODES; k++)
        begin
            node_dist[k] = 0;
            seen[k] = 1'b0;
        end
        // a source outside the nodes in use leaves everything unreached
        if (int'(model_source) < n)
            seen[model_source] = 1'b1;

        for (int p = 0; p + 1 < n; p++)
        begin
            for (int e = 0; e < list_len; e++)
            begin
                u = int'(list_tail[e]);
                v = int'(list_head[e]);
                // skip edges leaving the graph or starting from unreached tails
                if (u >= n || v >= n || !seen[u])
                    continue;
                cand = clamp_dist(node_dist[u] + longint'(list_cost[e]));
                if (!seen[v] || cand < node_dist[v])
                begin
                    node_dist[v] = cand;
                    seen[v] = 1'b1;
                end
            end
        end

        for (int k = 0; k < n; k++)
        begin
            rep.node_index = k[NODE_W-1:0];
            rep.distance   = seen[k] ? node_dist[k][DIST_W-1:0] : '0;
            rep.reachable  = seen[k];
            rep.last_node  = (k + 1 == n);
            pending_reports = {pending_reports, rep};
        end
        list_len = 0;
    endfunction

    // Store one accepted edge word; a full store drops it but the close mark
    // still starts the run.
    function automatic void store_edge(edge_word_t w);
        if (list_len < MAX_EDGES)
        begin
            list_tail[list_len] = w.tail;
            list_head[list_len] = w.head;
            list_cost[list_len] = w.cost;
            list_len++;
        end
        if (w.closing)
            solve_paths();
    endfunction

    function automatic edge_word_t edge_of(int t, int h, int c, bit l);
        edge_word_t w;
        w.tail    = t[NODE_W-1:0];
        w.head    = h[NODE_W-1:0];
        w.cost    = c[COST_BITS-1:0];
        w.closing = l;
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // Result checking: compare each accepted word with the oldest report.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        node_report_t want;
        if (rst_n && results_ch.valid && results_ch.ready)
        begin
            if (pending_reports.size() == 0)
            begin
                $error("unexpected results word: node_index %0d distance %0d",
                       results_ch.node_index, results_ch.distance);
                error_count++;
            end
            else
            begin
                want = pending_reports.pop_front();
                if (results_ch.node_index !== want.node_index)
                begin
                    $error("node_index: expected %0d, actual %0d",
                           want.node_index, results_ch.node_index);
                    error_count++;
                end
                if (results_ch.distance !== want.distance)
                begin
                    $error("distance (node %0d): expected %0d, actual %0d",
                           want.node_index, want.distance, results_ch.distance);
                    error_count++;
                end
                if (results_ch.reachable !== want.reachable)
                begin
                    $error("reachable (node %0d): expected %0b, actual %0b",
                           want.node_index, want.reachable, results_ch.reachable);
                    error_count++;
                end
                if (results_ch.last_node !== want.last_node)
                begin
                    $error("last_node (node %0d): expected %0b, actual %0b",
                           want.node_index, want.last_node, results_ch.last_node);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: switch stall pattern at random intervals; on request hold
    // ready low for one long stretch so the unit backs up into its input.
    // ------------------------------------------------------------------------
    initial
    begin
        rx_mode_t mode;
        int       left;
        mode = RX_OPEN;
        left = 0;
        results_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                results_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 1'b0;
                results_ch.ready <= 1'b1;
            end
            else
            begin
                if (left == 0)
                begin
                    mode = rx_mode_t'($urandom_range(0, 3));
                    left = $urandom_range(16, 96);
                end
                left--;
                case (mode)
                    RX_OPEN:    results_ch.ready <= 1'b1;
                    RX_COIN:    results_ch.ready <= 1'($urandom_range(0, 1));
                    RX_CADENCE: results_ch.ready <= (left % 3 != 0);
                    default:    results_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Count cycles in which no word moves on any channel.
    always @(posedge clk)
    begin
        if ((edges_ch.valid && edges_ch.ready) || (results_ch.valid && results_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Watchdog: a hung unit ends the run here.
    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sender helpers
    // ------------------------------------------------------------------------
    task automatic drop_valid();
        if (offering)
        begin
            edges_ch.valid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    // End a burst now and then with a random gap; zero gaps merge bursts.
    task automatic pace();
        int gap;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                drop_valid();
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Offer one edge word, wait for the handshake, then record it.
    task automatic send_edge(edge_word_t w);
        edges_ch.from_node <= w.tail;
        edges_ch.to_node   <= w.head;
        edges_ch.edge_cost <= w.cost;
        edges_ch.last_edge <= w.closing;
        if (!offering)
        begin
            edges_ch.valid <= 1'b1;
            offering = 1'b1;
        end
        @(posedge clk);
        while (!edges_ch.ready)
            @(posedge clk);
        store_edge(w);
        items_sent++;
        pace();
    endtask

    // Hold the sender until every report is in and the unit has gone quiet.
    task automatic await_idle();
        drop_valid();
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        cfg_ch.valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        if (idx == REG_SOURCE_NODE)
            model_source = val[SRC_W-1:0];
        else
            model_count = val;
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // One closed list of random length. Endpoints stay inside the nodes in use
    // unless noisy, where some of them land anywhere in the 5-bit range.
    task automatic send_random_list(bit noisy, int max_len);
        int         len;
        int         n;
        edge_word_t w;
        n = nodes_in_use();
        len = $urandom_range(1, max_len);
        for (int k = 0; k < len; k++)
        begin
            w.tail = (noisy && $urandom_range(0, 2) == 0) ? NODE_W'($urandom_range(0, 31))
                                                        : NODE_W'($urandom_range(0, n - 1));
            w.head = (noisy && $urandom_range(0, 2) == 0) ? NODE_W'($urandom_range(0, 31))
                                                        : NODE_W'($urandom_range(0, n - 1));
            if ($urandom_range(0, 2) == 0)
                w.cost = COST_BITS'($urandom_range(0, 65535));
            else
                w.cost = COST_BITS'(int'($urandom_range(0, 250)) - 50);
            w.closing = (k == len - 1);
            send_edge(w);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset registers: source 0, five nodes. Cost extremes on a short chain.
    task automatic test_reset_defaults();
        send_edge(edge_of(0, 1, 5, 1'b0));
        send_edge(edge_of(1, 2, -3, 1'b0));
        send_edge(edge_of(0, 2, 100, 1'b0));
        send_edge(edge_of(2, 3, -32768, 1'b0));
        send_edge(edge_of(3, 4, 32767, 1'b1));
    endtask

    // One node in use, and a node count of zero that acts as one: no passes.
    task automatic test_single_node();
        await_idle();
        write_reg(REG_NODE_COUNT, 6'd1);
        send_edge(edge_of(0, 0, -7, 1'b1));
        await_idle();
        write_reg(REG_NODE_COUNT, 6'd0);
        send_edge(edge_of(0, 0, 32767, 1'b1));
    endtask

    // Source at or above the node count: every node reports unreached.
    task automatic test_source_out_of_range();
        await_idle();
        write_reg(REG_NODE_COUNT, 6'd6);
        write_reg(REG_SOURCE_NODE, 6'd10);
        send_edge(edge_of(10, 1, 4, 1'b0));
        send_edge(edge_of(0, 1, 2, 1'b1));
    endtask

    // Edges touching nodes outside the graph are skipped.
    task automatic test_endpoint_out_of_range();
        await_idle();
        write_reg(REG_SOURCE_NODE, 6'd0);
        write_reg(REG_NODE_COUNT, 6'd4);
        send_edge(edge_of(0, 31, 1, 1'b0));
        send_edge(edge_of(31, 1, 1, 1'b0));
        send_edge(edge_of(0, 3, -32768, 1'b0));
        send_edge(edge_of(3, 1, 9, 1'b1));
    endtask

    // A negative cycle: distances after the last bounded pass are reported.
    task automatic test_negative_cycle();
        await_idle();
        write_reg(REG_SOURCE_NODE, 6'd1);
        send_edge(edge_of(1, 2, -4, 1'b0));
        send_edge(edge_of(2, 3, -4, 1'b0));
        send_edge(edge_of(3, 1, -4, 1'b0));
        send_edge(edge_of(2, 0, 7, 1'b1));
    endtask

    // Count above the store (acts as 32), source 31, a chain loaded back to
    // front so each pass extends it by one node.
    task automatic test_full_width();
        await_idle();
        write_reg(REG_NODE_COUNT, 6'd63);
        write_reg(REG_SOURCE_NODE, 6'd31);
        for (int i = 0; i < 8; i++)
            send_edge(edge_of(24 + i, 23 + i, i * 1000 - 3000, i == 7));
    endtask

    // A negative two-node loop listed many times over 32 nodes: every pass
    // walks the loop again until the sum pins at the distance floor.
    task automatic test_saturation();
        await_idle();
        write_reg(REG_NODE_COUNT, 6'd32);
        write_reg(REG_SOURCE_NODE, 6'd0);
        for (int i = 0; i < 16; i++)
            send_edge(edge_of(i % 2, (i + 1) % 2, -32768, i == 15));
    endtask

    // Hold the receiver off while several lists go in, so the unit fills up
    // and stalls its input; then pause the sender until everything is back.
    task automatic test_backpressure();
        await_idle();
        write_reg(REG_NODE_COUNT, 6'd8);
        hold_req = 1'b1;
        for (int i = 0; i < 3; i++)
            send_random_list(1'b0, 6);
        await_idle();
    endtask

    // Random graphs under random register settings, mostly well-formed.
    task automatic test_random_graphs();
        int start;
        int pick;
        int n;
        int lists;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            await_idle();
            pick = $urandom_range(0, 9);
            if (pick <= 6)
                write_reg(REG_NODE_COUNT, NCOUNT_W'($urandom_range(2, 8)));
            else if (pick == 7)
                write_reg(REG_NODE_COUNT, NCOUNT_W'($urandom_range(0, 1)));
            else if (pick == 8)
                write_reg(REG_NODE_COUNT, 6'd32);
            else
                write_reg(REG_NODE_COUNT, NCOUNT_W'($urandom_range(33, 63)));
            n = nodes_in_use();
            if ($urandom_range(0, 4) != 0)
                write_reg(REG_SOURCE_NODE, {1'($urandom_range(0, 1)),
                                            SRC_W'($urandom_range(0, n - 1))});
            else
                write_reg(REG_SOURCE_NODE, CFG_DATA_W'($urandom_range(0, 63)));
            lists = $urandom_range(1, 3);
            for (int i = 0; i < lists; i++)
                send_random_list($urandom_range(0, 6) == 0, 10);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_single_node();
        test_source_out_of_range();
        test_endpoint_out_of_range();
        test_negative_cycle();
        test_full_width();
        test_saturation();
        test_backpressure();
        test_random_graphs();

        await_idle();
        if (pending_reports.size() != 0)
        begin
            $error("%0d reports never arrived", pending_reports.size());
            error_count++;
        end
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
